// ===== hw/rtl/range_min_segment_tree_assert.svh =====
// assertion helpers for the segment tree rtl
`ifndef RANGE_MIN_SEGMENT_TREE_ASSERT_SVH
`define RANGE_MIN_SEGMENT_TREE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RMST_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition never holds
`define RMST_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/rmst_pkg.sv =====
package rmst_pkg;

  // tree geometry
  localparam int unsigned LEAVES     = 1024;
  localparam int unsigned NODE_COUNT = 2 * LEAVES - 1;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned IDX_W      = POS_W + 1;
  localparam int unsigned DATA_W     = 64;

  // node values
  localparam logic signed [DATA_W-1:0] INITIAL_MIN = 64'sd2147483647;
  localparam logic signed [DATA_W-1:0] MAX_S64     = {1'b0, {(DATA_W-1){1'b1}}};

  // request kinds
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

endpackage

// ===== hw/rtl/rmst_if.sv =====
// request channel
interface rmst_req_if import rmst_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [POS_W-1:0]         position;
  logic [POS_W-1:0]         range_last;
  logic signed [DATA_W-1:0] new_value;

  modport source (output valid, output req_type, output position, output range_last,
                  output new_value, input ready);
  modport sink   (input valid, input req_type, input position, input range_last,
                  input new_value, output ready);
endinterface

// response channel
interface rmst_rsp_if import rmst_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] range_minimum;

  modport source (output valid, output range_minimum, input ready);
  modport sink   (input valid, input range_minimum, output ready);
endinterface

// ===== hw/rtl/rmst_ram.sv =====
module rmst_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 2047,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/range_min_segment_tree.sv =====
// range minimum segment tree, one node ram, one shared 64-bit min unit
// update: 11 node reads on the root-to-leaf path, one trailing write
// query: a walk of at most 21 steps over two paths, then a drain; an empty range skips the walk
// one request at a time, taken only in idle, so a new request waits until the last is done
// reset: a clearing pass writes 2147483647 to all 2047 nodes, not ready
module range_min_segment_tree import rmst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmst_req_if.sink   req_i,
  rmst_rsp_if.source rsp_o
);

  `include "range_min_segment_tree_assert.svh"

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_UPD      = 3'd2;
  localparam logic [2:0] ST_UPD_LAST = 3'd3;
  localparam logic [2:0] ST_QRY      = 3'd4;
  localparam logic [2:0] ST_DRAIN    = 3'd5;
  localparam logic [2:0] ST_FINISH   = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [POS_W-1:0]         lo_q, lo_d, hi_q, hi_d, from_q, from_d, to_q, to_d;
  logic                     pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0]         pend_idx_q, pend_idx_d;
  logic [POS_W-1:0]         pend_lo_q, pend_lo_d, pend_hi_q, pend_hi_d, pend_to_q, pend_to_d;
  logic signed [DATA_W-1:0] val_q, val_d, acc_q, acc_d;
  logic                     rd_valid_q, rd_valid_d;
  logic                     wr_pend_q, wr_pend_d;
  logic [IDX_W-1:0]         wr_addr_q, wr_addr_d;
  logic                     rsp_valid_q, rsp_valid_d;
  logic signed [DATA_W-1:0] rsp_data_q, rsp_data_d;

  logic                     ram_we, ram_re;
  logic [IDX_W-1:0]         ram_waddr, ram_raddr;
  logic signed [DATA_W-1:0] ram_wdata, ram_rdata;
  logic                     push_pend;

  // node ram
  rmst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // split point and child indices of the current node
  logic [POS_W:0]   span_sum;
  logic [POS_W-1:0] mid, mid_p1, left_sz;
  logic [IDX_W-1:0] left_idx, right_idx;
  logic             covered, is_leaf;

  assign span_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = span_sum[POS_W:1];
  assign mid_p1    = mid + POS_W'(1);
  assign left_sz   = mid - lo_q + POS_W'(1);
  assign left_idx  = idx_q + IDX_W'(1);
  assign right_idx = idx_q + {left_sz, 1'b0};
  assign covered   = (from_q <= lo_q) && (hi_q <= to_q);
  assign is_leaf   = (lo_q == hi_q);

  // shared min unit: merge with update value or running minimum
  logic signed [DATA_W-1:0] min_b, min_out;

  assign min_b   = ((state_q == ST_UPD) || (state_q == ST_UPD_LAST)) ? val_q : acc_q;
  assign min_out = (ram_rdata < min_b) ? ram_rdata : min_b;

  // sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    from_d       = from_q;
    to_d         = to_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    pend_lo_d    = pend_lo_q;
    pend_hi_d    = pend_hi_q;
    pend_to_d    = pend_to_q;
    val_d        = val_q;
    acc_d        = acc_q;
    rd_valid_d   = 1'b0;
    wr_pend_d    = 1'b0;
    wr_addr_d    = wr_addr_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_data_d   = rsp_data_q;
    ram_we       = 1'b0;
    ram_waddr    = wr_addr_q;
    ram_wdata    = min_out;
    ram_re       = 1'b0;
    ram_raddr    = idx_q;
    push_pend    = 1'b0;

    // fold returning node data into the running minimum
    if (rd_valid_q) begin
      acc_d = min_out;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = INITIAL_MIN;
        if (idx_q == IDX_W'(NODE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      ST_IDLE: begin
        if (req_i.valid) begin
          idx_d        = '0;
          lo_d         = '0;
          hi_d         = POS_W'(LEAVES - 1);
          from_d       = req_i.position;
          to_d         = req_i.range_last;
          val_d        = req_i.new_value;
          pend_valid_d = 1'b0;
          unique case (req_i.req_type)
            REQ_UPDATE: begin
              state_d = ST_UPD;
            end
            REQ_QUERY: begin
              if (req_i.position > req_i.range_last) begin
                acc_d   = '0;
                state_d = ST_FINISH;
              end else begin
                acc_d   = MAX_S64;
                state_d = ST_QRY;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // read node on the path, write each node back in the cycle after its read
      ST_UPD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        wr_pend_d = 1'b1;
        wr_addr_d = idx_q;
        ram_we    = wr_pend_q;
        if (is_leaf) begin
          state_d = ST_UPD_LAST;
        end else if (from_q <= mid) begin
          idx_d = left_idx;
          hi_d  = mid;
        end else begin
          idx_d = right_idx;
          lo_d  = mid_p1;
        end
      end

      ST_UPD_LAST: begin
        ram_we  = wr_pend_q;
        state_d = ST_IDLE;
      end

      // walk the canonical cover, at most one node read per cycle
      ST_QRY: begin
        priority if (covered) begin
          ram_re     = 1'b1;
          ram_raddr  = idx_q;
          rd_valid_d = 1'b1;
          if (pend_valid_q) begin
            idx_d        = pend_idx_q;
            lo_d         = pend_lo_q;
            hi_d         = pend_hi_q;
            from_d       = pend_lo_q;
            to_d         = pend_to_q;
            pend_valid_d = 1'b0;
          end else begin
            state_d = ST_DRAIN;
          end
        end else if (from_q > mid) begin
          idx_d = right_idx;
          lo_d  = mid_p1;
        end else if (to_q <= mid) begin
          idx_d = left_idx;
          hi_d  = mid;
        end else if (to_q >= hi_q) begin
          // right child fully inside: take it, go on left
          ram_re     = 1'b1;
          ram_raddr  = right_idx;
          rd_valid_d = 1'b1;
          idx_d      = left_idx;
          hi_d       = mid;
          to_d       = mid;
        end else if (from_q <= lo_q) begin
          // left child fully inside: take it, go on right
          ram_re     = 1'b1;
          ram_raddr  = left_idx;
          rd_valid_d = 1'b1;
          idx_d      = right_idx;
          lo_d       = mid_p1;
          from_d     = mid_p1;
        end else begin
          // first real split: park the right half
          push_pend    = 1'b1;
          pend_valid_d = 1'b1;
          pend_idx_d   = right_idx;
          pend_lo_d    = mid_p1;
          pend_hi_d    = hi_q;
          pend_to_d    = to_q;
          idx_d        = left_idx;
          hi_d         = mid;
          to_d         = mid;
        end
      end

      ST_DRAIN: begin
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_data_d  = acc_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      rd_valid_q   <= 1'b0;
      wr_pend_q    <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      rd_valid_q   <= rd_valid_d;
      wr_pend_q    <= wr_pend_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    from_q     <= from_d;
    to_q       <= to_d;
    pend_idx_q <= pend_idx_d;
    pend_lo_q  <= pend_lo_d;
    pend_hi_q  <= pend_hi_d;
    pend_to_q  <= pend_to_d;
    val_q      <= val_d;
    acc_q      <= acc_d;
    wr_addr_q  <= wr_addr_d;
    rsp_data_q <= rsp_data_d;
  end

  assign req_i.ready         = (state_q == ST_IDLE);
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.range_minimum = rsp_data_q;

  // checks
  `RMST_ASSERT_IMPLY(a_we_state, ram_we, (state_q == ST_CLEAR) || (state_q == ST_UPD) || (state_q == ST_UPD_LAST), "node write outside clear or update")
  `RMST_ASSERT_IMPLY(a_waddr_range, ram_we, ram_waddr < IDX_W'(NODE_COUNT), "node write address out of range")
  `RMST_ASSERT_NEVER(a_pend_once, push_pend && pend_valid_q, "second split while right half parked")
  `RMST_ASSERT_IMPLY(a_rd_state, rd_valid_q, (state_q == ST_QRY) || (state_q == ST_DRAIN), "query read data returned outside a query")
  `RMST_ASSERT_IMPLY(a_rsp_src, $rose(rsp_valid_q), $past(state_q) == ST_FINISH, "response raised without finishing a query")

endmodule
